>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define WPIP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define WPIP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`endif

>>> rtl/wpip_pkg.sv
// ----------------------------------------------------------------------------
// wpip_pkg
// Widths, register selects and stream layout of the wrapped polygon test.
// ----------------------------------------------------------------------------
`default_nettype none

package wpip_pkg;

	localparam int COORD_WIDTH_DEF = 12;
	localparam int POINT_W         = 11;
	localparam int MAP_W           = 12;
	localparam logic [MAP_W-1:0] MAP_RESET = MAP_W'(64);

	// A wrapped query copy is a point coordinate plus a map size.
	localparam int QUERY_W = ((MAP_W > POINT_W) ? MAP_W : POINT_W) + 1;

	localparam int NUM_COPIES = 4;
	localparam int NUM_EDGES  = 2;

	// Edge slots handled for each item.
	localparam int EDGE_PREV  = 0;
	localparam int EDGE_CLOSE = 1;

	// Stream sideband layout.
	localparam int TUSER_W     = 2;
	localparam int TUSER_FIRST = 0;
	localparam int TUSER_EMPTY = 1;
	localparam int OUT_TDATA_W = 8;

	// Register file: two 32-bit registers at byte addresses 0 and 4.
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;
	localparam int REG_SEL_BIT = 2;

	typedef enum logic {
		REG_MAP_WIDTH  = 1'b0,
		REG_MAP_HEIGHT = 1'b1
	} reg_sel_t;

endpackage

`default_nettype wire

>>> rtl/wrapped_point_in_polygon_core.sv
// ----------------------------------------------------------------------------
// wrapped_point_in_polygon_core
// Crossing-number point-in-polygon test for a point and its three copies
// shifted by the map width, the map height and both.
// ----------------------------------------------------------------------------
//  channel    direction  payload
//  s_axis     in         tdata: vertex_x, vertex_y, point_x, point_y
//                        tuser: first_vertex, empty_polygon; tlast: last_vertex
//  m_axis     out        tdata[0]: point_allowed
//  apb        in/out     map_width at 0x0, map_height at 0x4
//
//  One vertex is accepted every cycle while s_axis_tready is high; tvalid of a
//  result rises once the closing or empty item has passed the input, product and
//  result registers. The edge tests of one vertex, for both edges and every copy, run in parallel.
//  A stalled result blocks the product stage only while that holds another
//  result item, and the input stage and the input then stop behind it.
//  Reset sets both map sizes to 64 and clears valid bits and polygon state only.
// ----------------------------------------------------------------------------
`default_nettype none

module wrapped_point_in_polygon_core
	import wpip_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	localparam int TDATA_W = ((2 * COORD_WIDTH + 2 * POINT_W + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// vertex_x, vertex_y, point_x, point_y, zero padding
	input  logic [TDATA_W-1:0]    s_axis_tdata,
	// first_vertex, empty_polygon
	input  logic [TUSER_W-1:0]    s_axis_tuser,
	input  logic                  s_axis_tlast,

	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// point_allowed, zero padding
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,

	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int CW  = COORD_WIDTH;
	localparam int OW  = (CW > QUERY_W) ? CW : QUERY_W;
	localparam int DW  = OW + 1;
	localparam int PRW = 2 * DW;

	// Configuration registers.
	logic [MAP_W-1:0] map_width_q, map_height_q;

	// Polygon state.
	logic [CW-1:0]      first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic [POINT_W-1:0] query_x_q, query_y_q;
	logic [NUM_COPIES-1:0] flags_q;

	// Input stage.
	logic               v_s1;
	logic [CW-1:0]      vx_s1, vy_s1;
	logic [POINT_W-1:0] ptx_s1, pty_s1;
	logic               first_s1, last_s1, empty_s1;

	// Product stage.
	logic               v_s2;
	logic               first_s2, last_s2, empty_s2;
	logic                 straddle_s2 [NUM_EDGES][NUM_COPIES];
	logic                 dyneg_s2    [NUM_EDGES][NUM_COPIES];
	logic signed [PRW-1:0] lhs_s2     [NUM_EDGES][NUM_COPIES];
	logic signed [PRW-1:0] rhs_s2     [NUM_EDGES][NUM_COPIES];

	// Result register.
	logic out_valid_q, allowed_q;

	// Flow control.
	logic in_fire, out_ready, res_s2, adv_s2, s2_ready, adv_s1;

	assign out_ready     = !out_valid_q || m_axis_tready;
	assign res_s2        = last_s2 || empty_s2;
	assign adv_s2        = v_s2 && (!res_s2 || out_ready);
	assign s2_ready      = !v_s2 || adv_s2;
	assign adv_s1        = v_s1 && s2_ready;
	assign s_axis_tready = !v_s1 || s2_ready;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------
	logic     cfg_wr;
	reg_sel_t cfg_sel;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_sel = reg_sel_t'(paddr[REG_SEL_BIT]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= MAP_RESET;
			map_height_q <= MAP_RESET;
		end else if (cfg_wr) begin
			case (cfg_sel)
				REG_MAP_WIDTH:  map_width_q  <= pwdata[MAP_W-1:0];
				REG_MAP_HEIGHT: map_height_q <= pwdata[MAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_sel)
			REG_MAP_WIDTH:  prdata = APB_DATA_W'(map_width_q);
			REG_MAP_HEIGHT: prdata = APB_DATA_W'(map_height_q);
			default:        prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Input stage
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			vx_s1    <= s_axis_tdata[CW-1:0];
			vy_s1    <= s_axis_tdata[2*CW-1:CW];
			ptx_s1   <= s_axis_tdata[2*CW+POINT_W-1:2*CW];
			pty_s1   <= s_axis_tdata[2*CW+2*POINT_W-1:2*CW+POINT_W];
			first_s1 <= s_axis_tuser[TUSER_FIRST];
			empty_s1 <= s_axis_tuser[TUSER_EMPTY];
			last_s1  <= s_axis_tlast;
		end
	end

	// The polygon state follows the items in order as they leave the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q <= '0;
			first_y_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			query_x_q <= '0;
			query_y_q <= '0;
		end else if (adv_s1 && !empty_s1) begin
			prev_x_q <= vx_s1;
			prev_y_q <= vy_s1;
			if (first_s1) begin
				first_x_q <= vx_s1;
				first_y_q <= vy_s1;
				query_x_q <= ptx_s1;
				query_y_q <= pty_s1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Edge tests: straddle check and the two cross products per copy
	// ------------------------------------------------------------------
	logic [POINT_W-1:0] qx, qy;
	logic [CW-1:0]      fx, fy;
	logic [OW-1:0]      ax [NUM_EDGES];
	logic [OW-1:0]      ay [NUM_EDGES];
	logic [OW-1:0]      bx [NUM_EDGES];
	logic [OW-1:0]      by [NUM_EDGES];
	logic [OW-1:0]      px [NUM_COPIES];
	logic [OW-1:0]      py [NUM_COPIES];
	logic signed [DW-1:0] dy  [NUM_EDGES];
	logic signed [DW-1:0] dbx [NUM_EDGES];
	logic signed [DW-1:0] dpx [NUM_EDGES][NUM_COPIES];
	logic signed [DW-1:0] dpy [NUM_EDGES][NUM_COPIES];
	logic                 straddle_c [NUM_EDGES][NUM_COPIES];
	logic                 dyneg_c    [NUM_EDGES][NUM_COPIES];
	logic signed [PRW-1:0] lhs_c     [NUM_EDGES][NUM_COPIES];
	logic signed [PRW-1:0] rhs_c     [NUM_EDGES][NUM_COPIES];

	always_comb begin
		// A first vertex brings its own query point and closing vertex.
		qx = first_s1 ? ptx_s1 : query_x_q;
		qy = first_s1 ? pty_s1 : query_y_q;
		fx = first_s1 ? vx_s1  : first_x_q;
		fy = first_s1 ? vy_s1  : first_y_q;

		ax[EDGE_PREV]  = OW'(vx_s1);
		ay[EDGE_PREV]  = OW'(vy_s1);
		bx[EDGE_PREV]  = OW'(prev_x_q);
		by[EDGE_PREV]  = OW'(prev_y_q);
		ax[EDGE_CLOSE] = OW'(fx);
		ay[EDGE_CLOSE] = OW'(fy);
		bx[EDGE_CLOSE] = OW'(vx_s1);
		by[EDGE_CLOSE] = OW'(vy_s1);

		for (int k = 0; k < NUM_COPIES; k++) begin
			px[k] = OW'(qx) + (((k & 1) != 0) ? OW'(map_width_q)  : '0);
			py[k] = OW'(qy) + (((k & 2) != 0) ? OW'(map_height_q) : '0);
		end

		for (int e = 0; e < NUM_EDGES; e++) begin
			dy[e]  = $signed({1'b0, by[e]}) - $signed({1'b0, ay[e]});
			dbx[e] = $signed({1'b0, bx[e]}) - $signed({1'b0, ax[e]});
			for (int k = 0; k < NUM_COPIES; k++) begin
				straddle_c[e][k] = (ay[e] > py[k]) != (by[e] > py[k]);
				dyneg_c[e][k]    = by[e] < ay[e];
				dpx[e][k] = $signed({1'b0, px[k]}) - $signed({1'b0, ax[e]});
				dpy[e][k] = $signed({1'b0, py[k]}) - $signed({1'b0, ay[e]});
				lhs_c[e][k] = dpx[e][k] * dy[e];
				rhs_c[e][k] = dbx[e] * dpy[e][k];
			end
		end
	end

	// ------------------------------------------------------------------
	// Product stage
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_ready) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			first_s2 <= first_s1;
			last_s2  <= last_s1;
			empty_s2 <= empty_s1;
			straddle_s2 <= straddle_c;
			dyneg_s2    <= dyneg_c;
			lhs_s2      <= lhs_c;
			rhs_s2      <= rhs_c;
		end
	end

	// ------------------------------------------------------------------
	// Parity update and result
	// ------------------------------------------------------------------
	logic [NUM_COPIES-1:0] cross_prev, cross_close, flags_next;

	always_comb begin
		for (int k = 0; k < NUM_COPIES; k++) begin
			cross_prev[k] = straddle_s2[EDGE_PREV][k] && (dyneg_s2[EDGE_PREV][k]
				? (lhs_s2[EDGE_PREV][k] > rhs_s2[EDGE_PREV][k])
				: (lhs_s2[EDGE_PREV][k] < rhs_s2[EDGE_PREV][k]));
			cross_close[k] = straddle_s2[EDGE_CLOSE][k] && (dyneg_s2[EDGE_CLOSE][k]
				? (lhs_s2[EDGE_CLOSE][k] > rhs_s2[EDGE_CLOSE][k])
				: (lhs_s2[EDGE_CLOSE][k] < rhs_s2[EDGE_CLOSE][k]));
		end
		// A first vertex starts from clear flags and has no edge to a previous one.
		flags_next = first_s2 ? '0 : (flags_q ^ cross_prev);
		if (last_s2) begin
			flags_next = flags_next ^ cross_close;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (adv_s2 && !empty_s2) begin
			flags_q <= flags_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= adv_s2 && res_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && adv_s2 && res_s2) begin
			allowed_q <= empty_s2 || (|flags_next);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'(allowed_q);

endmodule

`default_nettype wire

>>> rtl/wpip_checker.sv
// ----------------------------------------------------------------------------
// wpip_checker
// Port-level checks of the wrapped polygon test, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module wpip_checker
	import wpip_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                   psel,
	input logic                   penable,
	input logic                   pwrite,
	input logic                   pready,
	input logic [APB_ADDR_W-1:0]  paddr,
	input logic [APB_DATA_W-1:0]  pwdata,
	input logic [APB_DATA_W-1:0]  prdata
);

	// A result that is not taken stays, unchanged.
	`WPIP_ASSERT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result dropped or changed")

	// Only the lowest data bit carries the result.
	`WPIP_ASSERT_NEVER(a_out_pad, clk, arst_n, m_axis_tdata[OUT_TDATA_W-1:1] != '0, "result padding bits not zero")

	// With an empty result register, a result comes from an item that passed both stages.
	`WPIP_ASSERT(a_out_origin, clk, arst_n, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 3), "result without a matching input item")

	// A written map size reads back in the next cycle.
	`WPIP_ASSERT(a_cfg_readback, clk, arst_n, psel && penable && pwrite && pready ##1 (paddr[REG_SEL_BIT] == $past(paddr[REG_SEL_BIT])) |-> prdata == APB_DATA_W'($past(pwdata[MAP_W-1:0])), "register readback mismatch")

endmodule

bind wrapped_point_in_polygon_core wpip_checker u_wpip_checker (.*);

`default_nettype wire
